### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define CHK_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ilfsr_pkg.sv
// ---------------------------------------------------------------------------
// ilfsr_pkg
// Types and constants of the idle-line frame slot receiver.
// ---------------------------------------------------------------------------
package ilfsr_pkg;

    localparam int SLOT_COUNT     = 4;
    localparam int BUF_BYTES      = 64;
    localparam int ADDR_W         = $clog2(BUF_BYTES);
    localparam int SLOT_W         = 2;
    localparam int BYTE_W         = 8;
    localparam int OFF_W          = 6;
    localparam int LEN_W          = 6;
    localparam int ACT_W          = 3;
    localparam int OUTC_W         = 3;
    localparam int SLOT_MEM_DEPTH = SLOT_COUNT * BUF_BYTES;
    localparam int SLOT_MEM_AW    = SLOT_W + ADDR_W;
    localparam int IN_DATA_W      = 16;
    localparam int OUT_DATA_W     = 24;

    typedef enum logic [ACT_W-1:0] {
        ACT_BYTE     = 3'd0,
        ACT_LINE_ERR = 3'd1,
        ACT_IDLE     = 3'd2,
        ACT_READ     = 3'd3,
        ACT_RELEASE  = 3'd4
    } t_action;

    typedef enum logic [OUTC_W-1:0] {
        OUT_TAKEN       = 3'd0,
        OUT_DROPPED     = 3'd1,
        OUT_FRAME_RESET = 3'd2,
        OUT_STORED      = 3'd3,
        OUT_FRAME_DROP  = 3'd4,
        OUT_EMPTY_IDLE  = 3'd5,
        OUT_READ        = 3'd6,
        OUT_RELEASED    = 3'd7
    } t_outcome;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COPY,
        ST_READ
    } t_state;

    // Result payload, slot_index in the lowest bits.
    typedef struct packed {
        logic [SLOT_COUNT-1:0] full_mask;
        logic [BYTE_W-1:0]     read_byte;
        logic [LEN_W-1:0]      frame_length;
        logic [SLOT_W-1:0]     slot_index;
    } t_result;

endpackage

### hw/rtl/idle_line_frame_slot_receiver.sv
// ---------------------------------------------------------------------------
// idle_line_frame_slot_receiver
// Assembles received serial bytes into frames ended by an idle line and
// files each frame into the first free slot of a small pool.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Sideband (tuser)       Payload (tdata)
//  s_axis    in         action                 rx_byte, slot_select, byte_offset
//  m_axis    out        outcome                slot_index, frame_length,
//                                              read_byte, full_mask
//
//  Byte received, line error, release, empty idle and dropped frame: the
//  result is registered in the cycle after the transaction.
//  Read slot byte: the slot memory read is registered, then ST_READ loads the result.
//  Stored frame: ST_COPY moves one byte a cycle through the assembly memory
//  read port and the slot memory write port, then loads the result.
//  Input tready stays low while a copy or read runs and while a result waits
//  downstream; reset (synchronous, active low) clears counts, lengths and
//  full bits, and the byte memories come up unwritten.
// ---------------------------------------------------------------------------
module idle_line_frame_slot_receiver (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] rx_byte, [9:8] slot_select, [15:10] byte_offset
    input  logic [ilfsr_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // [2:0] action
    input  logic [ilfsr_pkg::ACT_W-1:0]     s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [1:0] slot_index, [7:2] frame_length, [15:8] read_byte,
    // [19:16] full_mask, [23:20] zero
    output logic [ilfsr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [2:0] outcome
    output logic [ilfsr_pkg::OUTC_W-1:0]    m_axis_tuser
);
    import ilfsr_pkg::*;

    // Sequencer and frame state
    t_state                r_state, n_state;
    logic [ADDR_W-1:0]     r_count, n_count;
    logic [SLOT_COUNT-1:0] r_full, n_full;
    logic [ADDR_W-1:0]     r_len [SLOT_COUNT];
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic [ADDR_W-1:0]     r_copy_len, n_copy_len;
    logic [ADDR_W-1:0]     r_idx, n_idx;
    logic [ADDR_W-1:0]     r_off, n_off;
    logic                  r_sel_ok, n_sel_ok;

    // Output register
    logic                  r_out_valid;
    t_result               r_out_data;
    logic [OUTC_W-1:0]     r_out_kind;

    // Memories
    logic [BYTE_W-1:0]     asm_mem  [BUF_BYTES];
    logic [BYTE_W-1:0]     slot_mem [SLOT_MEM_DEPTH];
    logic [BYTE_W-1:0]     r_asm_q;
    logic [BYTE_W-1:0]     r_slot_q;

    // Unpacked transaction
    logic                  accept;
    logic [ACT_W-1:0]      in_action;
    logic [BYTE_W-1:0]     in_rx;
    logic [SLOT_W-1:0]     in_sel;
    logic [OFF_W-1:0]      in_off;
    logic                  in_sel_ok;

    // Control from the sequencer
    logic                  asm_we;
    logic [ADDR_W-1:0]     asm_ra;
    logic                  slot_we;
    logic [SLOT_MEM_AW-1:0] slot_wa;
    logic                  slot_re;
    logic [SLOT_MEM_AW-1:0] slot_ra;
    logic                  len_we;
    logic                  out_load;
    t_result               out_data;
    logic [OUTC_W-1:0]     out_kind;
    logic                  free_found;
    logic [SLOT_W-1:0]     free_idx;

    assign in_action = s_axis_tuser;
    assign in_rx     = s_axis_tdata[7:0];
    assign in_sel    = s_axis_tdata[9:8];
    assign in_off    = s_axis_tdata[15:10];
    assign in_sel_ok = ({1'b0, in_sel} < (SLOT_W + 1)'(SLOT_COUNT));

    // Take a new transaction only between items, and only once the result
    // register is empty or being emptied this cycle.
    assign s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Lowest-numbered free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_full[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // Next state, memory control and result
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_full     = r_full;
        n_slot     = r_slot;
        n_copy_len = r_copy_len;
        n_idx      = r_idx;
        n_off      = r_off;
        n_sel_ok   = r_sel_ok;
        asm_we     = 1'b0;
        asm_ra     = r_idx;
        slot_we    = 1'b0;
        slot_wa    = {r_slot, r_idx - ADDR_W'(1)};
        slot_re    = 1'b0;
        slot_ra    = {in_sel, ADDR_W'(in_off)};
        len_we     = 1'b0;
        out_load   = 1'b0;
        out_kind   = OUT_TAKEN;
        out_data   = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (in_action)
                        ACT_BYTE: begin
                            out_load = 1'b1;
                            out_data.full_mask = r_full;
                            if (r_count < ADDR_W'(BUF_BYTES - 1)) begin
                                asm_we   = 1'b1;
                                n_count  = r_count + ADDR_W'(1);
                                out_kind = OUT_TAKEN;
                                out_data.frame_length = LEN_W'(r_count + ADDR_W'(1));
                            end else begin
                                out_kind = OUT_DROPPED;
                                out_data.frame_length = LEN_W'(r_count);
                            end
                        end
                        ACT_LINE_ERR: begin
                            // Discard the partial frame.
                            n_count  = '0;
                            out_load = 1'b1;
                            out_kind = OUT_FRAME_RESET;
                            out_data.full_mask = r_full;
                        end
                        ACT_IDLE: begin
                            n_count = '0;
                            if (r_count == '0) begin
                                out_load = 1'b1;
                                out_kind = OUT_EMPTY_IDLE;
                                out_data.full_mask = r_full;
                            end else if (free_found) begin
                                // Claim the slot now, copy over the next cycles.
                                n_slot     = free_idx;
                                n_copy_len = r_count;
                                n_idx      = '0;
                                n_full[free_idx] = 1'b1;
                                len_we     = 1'b1;
                                n_state    = ST_COPY;
                            end else begin
                                out_load = 1'b1;
                                out_kind = OUT_FRAME_DROP;
                                out_data.frame_length = LEN_W'(r_count);
                                out_data.full_mask    = r_full;
                            end
                        end
                        ACT_READ: begin
                            slot_re  = in_sel_ok;
                            n_slot   = in_sel;
                            n_off    = ADDR_W'(in_off);
                            n_sel_ok = in_sel_ok;
                            n_state  = ST_READ;
                        end
                        ACT_RELEASE: begin
                            out_load = 1'b1;
                            out_kind = OUT_RELEASED;
                            out_data.slot_index = in_sel;
                            if (in_sel_ok) begin
                                n_full[in_sel] = 1'b0;
                                out_data.frame_length = LEN_W'(r_len[in_sel]);
                            end
                            out_data.full_mask = n_full;
                        end
                        default: begin
                            // Unused action codes: drop without a result.
                        end
                    endcase
                end
            end
            ST_COPY: begin
                // Read byte idx while writing byte idx-1 fetched last cycle.
                slot_we = (r_idx != '0);
                if (r_idx == r_copy_len) begin
                    out_load = 1'b1;
                    out_kind = OUT_STORED;
                    out_data.slot_index   = r_slot;
                    out_data.frame_length = LEN_W'(r_copy_len);
                    out_data.full_mask    = r_full;
                    n_state  = ST_IDLE;
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end
            ST_READ: begin
                out_load = 1'b1;
                out_kind = OUT_READ;
                out_data.slot_index = r_slot;
                out_data.full_mask  = r_full;
                if (r_sel_ok) begin
                    out_data.frame_length = LEN_W'(r_len[r_slot]);
                    if (r_off < r_len[r_slot]) begin
                        out_data.read_byte = r_slot_q;
                    end
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_full   <= '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_len[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_full  <= n_full;
            if (len_we) begin
                r_len[free_idx] <= r_count;
            end
        end
    end

    // Sequencer payload registers
    always_ff @(posedge i_clk) begin
        r_slot     <= n_slot;
        r_copy_len <= n_copy_len;
        r_idx      <= n_idx;
        r_off      <= n_off;
        r_sel_ok   <= n_sel_ok;
    end

    // Result register: load on completion, drop once taken downstream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= out_data;
            r_out_kind <= out_kind;
        end
    end

    // Assembly buffer: written on a received byte, read by the copy loop.
    always_ff @(posedge i_clk) begin
        if (asm_we) begin
            asm_mem[r_count] <= in_rx;
        end
        r_asm_q <= asm_mem[asm_ra];
    end

    // Slot pool: written by the copy loop, read by a read transaction.
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_wa] <= r_asm_q;
        end
        if (slot_re) begin
            r_slot_q <= slot_mem[slot_ra];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_out_data);
    assign m_axis_tuser  = r_out_kind;

endmodule

### hw/rtl/ilfsr_checker.sv
// ---------------------------------------------------------------------------
// ilfsr_checker
// Port-level checks of the idle-line frame slot receiver.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ilfsr_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [ilfsr_pkg::ACT_W-1:0]      s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [ilfsr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [ilfsr_pkg::OUTC_W-1:0]     m_axis_tuser
);
    import ilfsr_pkg::*;

    logic                           s_acc;
    logic                           m_stall;
    logic                           byte_acc;
    logic                           err_acc;
    logic                           byte_out;
    logic                           err_out;
    logic [OUT_DATA_W+OUTC_W:0]     m_word;

    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign m_stall  = m_axis_tvalid && !m_axis_tready;
    assign byte_acc = s_acc && (s_axis_tuser == ACT_BYTE);
    assign err_acc  = s_acc && (s_axis_tuser == ACT_LINE_ERR);
    assign byte_out = m_axis_tvalid &&
                      (m_axis_tuser == OUT_TAKEN || m_axis_tuser == OUT_DROPPED);
    assign err_out  = m_axis_tvalid && (m_axis_tuser == OUT_FRAME_RESET) &&
                      (m_axis_tdata[7:0] == 8'd0);
    // Whole output side: a held result keeps valid, sideband and payload.
    assign m_word   = {m_axis_tvalid, m_axis_tuser, m_axis_tdata};

    `CHK_NEXT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n, !m_axis_tvalid, "result after reset")
    `CHK_NEXT(a_stall_holds, i_clk, i_rst_n, m_stall, $stable(m_word), "held result changed")
    `CHK_IMPLY(a_no_take_on_stall, i_clk, i_rst_n, m_stall, !s_axis_tready, "input taken in stall")
    `CHK_NEXT(a_byte_result, i_clk, i_rst_n, byte_acc, byte_out, "byte without prompt result")
    `CHK_NEXT(a_line_err_result, i_clk, i_rst_n, err_acc, err_out, "bad frame reset result")

endmodule

bind idle_line_frame_slot_receiver ilfsr_checker u_ilfsr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
